// ===== rtl/fca_pkg.sv =====
package fca_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned ANGLE_LEN        = 30;
  localparam int unsigned STEP_W           = 5;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic [31:0] PREFACTOR_RST    = 32'h0001_0000;
  localparam logic signed [63:0] SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN   = 64'sh8000_0000_0000_0000;

  typedef enum logic [0:0] {
    REG_WAVENUMBER = 1'b0,
    REG_PREFACTOR  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_PHASE,
    MUL_COS,
    MUL_SIN,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_LOAD,
    ST_ROTATE,
    ST_MUL_COS,
    ST_MUL_SIN,
    ST_ADD_SIN,
    ST_WAIT_OUT,
    ST_SC_LO,
    ST_SC_HI,
    ST_SC_ADD
  } state_t;

  typedef struct packed {
    logic     capture_in;
    mul_sel_t mul_sel;
    logic     load_cordic;
    logic     rotate;
    logic     acc_even;
    logic     acc_odd;
    logic     hold_lo;
    logic     scale_odd;
    logic     write_scaled;
    logic     clear_acc;
  } cmd_t;

  typedef struct packed {
    logic rot_last;
    logic last;
  } status_t;

  // atan(2^-i) in units of 2^-32 turn, truncated.
  function automatic logic [31:0] angle_turn(input logic [STEP_W-1:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2E;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2F9;
      5'd15:   a = 32'h0000517C;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A2F;
      5'd19:   a = 32'h00000517;
      5'd20:   a = 32'h0000028B;
      5'd21:   a = 32'h00000145;
      5'd22:   a = 32'h000000A2;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000028;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000002;
      5'd29:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // Saturating 64-bit add; bit 64 of the result flags saturation.
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] s;
    logic [64:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, SUM_MIN} : {1'b1, SUM_MAX};
    end else begin
      r = {1'b0, s[63:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/fca_ctrl.sv =====
module fca_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fca_pkg::status_t    status,
  output fca_pkg::cmd_t       cmd
);

  fca_pkg::state_t state, state_next;
  logic            pass, pass_next;
  logic            out_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fca_pkg::ST_IDLE;
      pass      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next       = state;
    pass_next        = pass;
    out_set          = 1'b0;
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.mul_sel      = fca_pkg::MUL_PHASE;
    cmd.scale_odd    = pass;
    case (state)
      fca_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture_in = 1'b1;
          state_next     = fca_pkg::ST_PHASE;
        end
      end
      fca_pkg::ST_PHASE: begin
        cmd.mul_sel = fca_pkg::MUL_PHASE;
        state_next  = fca_pkg::ST_LOAD;
      end
      fca_pkg::ST_LOAD: begin
        cmd.load_cordic = 1'b1;
        state_next      = fca_pkg::ST_ROTATE;
      end
      fca_pkg::ST_ROTATE: begin
        cmd.rotate = 1'b1;
        if (status.rot_last) begin
          state_next = fca_pkg::ST_MUL_COS;
        end
      end
      fca_pkg::ST_MUL_COS: begin
        cmd.mul_sel = fca_pkg::MUL_COS;
        state_next  = fca_pkg::ST_MUL_SIN;
      end
      fca_pkg::ST_MUL_SIN: begin
        cmd.mul_sel  = fca_pkg::MUL_SIN;
        cmd.acc_even = 1'b1;
        state_next   = fca_pkg::ST_ADD_SIN;
      end
      fca_pkg::ST_ADD_SIN: begin
        cmd.acc_odd = 1'b1;
        state_next  = status.last ? fca_pkg::ST_WAIT_OUT : fca_pkg::ST_IDLE;
      end
      fca_pkg::ST_WAIT_OUT: begin
        // The output register is written during scaling, so it must be free.
        if (!out_valid || out_ready) begin
          pass_next  = 1'b0;
          state_next = fca_pkg::ST_SC_LO;
        end
      end
      fca_pkg::ST_SC_LO: begin
        cmd.mul_sel = fca_pkg::MUL_LO;
        state_next  = fca_pkg::ST_SC_HI;
      end
      fca_pkg::ST_SC_HI: begin
        cmd.mul_sel = fca_pkg::MUL_HI;
        cmd.hold_lo = 1'b1;
        state_next  = fca_pkg::ST_SC_ADD;
      end
      fca_pkg::ST_SC_ADD: begin
        cmd.write_scaled = 1'b1;
        if (pass) begin
          cmd.clear_acc = 1'b1;
          out_set       = 1'b1;
          state_next    = fca_pkg::ST_IDLE;
        end else begin
          pass_next  = 1'b1;
          state_next = fca_pkg::ST_SC_LO;
        end
      end
      default: begin
        state_next = fca_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fca_datapath.sv =====
module fca_datapath #(
  parameter int unsigned CORDIC_STEPS = fca_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [0:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic signed [31:0]   quantity,
  input  logic signed [31:0]   position,
  input  logic                 last,
  input  fca_pkg::cmd_t        cmd,
  output fca_pkg::status_t     status,
  output logic signed [63:0]   coefficient_even,
  output logic signed [63:0]   coefficient_odd,
  output logic                 saturated
);

  localparam int unsigned STEPS_RUN =
    (CORDIC_STEPS > fca_pkg::ANGLE_LEN) ? fca_pkg::ANGLE_LEN : CORDIC_STEPS;

  logic [31:0]          wavenumber_turns;
  logic signed [31:0]   prefactor;
  logic signed [31:0]   q_reg;
  logic signed [31:0]   pos_reg;
  logic                 last_reg;
  logic signed [63:0]   even_sum;
  logic signed [63:0]   odd_sum;
  logic                 overflow_seen;

  logic signed [33:0]   x, y, z;
  logic                 flip;
  logic [fca_pkg::STEP_W-1:0] cnt;

  logic signed [32:0]   mul_a;
  logic signed [34:0]   mul_b;
  logic signed [67:0]   mul_p;
  logic signed [67:0]   pp_lo;

  logic [31:0]          phase;
  logic [31:0]          p_rot;
  logic signed [33:0]   dx, dy;
  logic signed [33:0]   angle;
  logic signed [33:0]   cos_v, sin_v;
  logic signed [67:0]   prod_sh;
  logic [64:0]          add_even, add_odd;
  logic signed [63:0]   sum_sel;
  logic signed [95:0]   total;
  logic [79:0]          shifted;
  logic                 sc_sat;
  logic signed [63:0]   sc_val;

  always_comb begin
    cos_v = flip ? -x : x;
    sin_v = flip ? -y : y;
    sum_sel = cmd.scale_odd ? odd_sum : even_sum;
    mul_a = {1'b0, wavenumber_turns};
    mul_b = {{3{pos_reg[31]}}, pos_reg};
    case (cmd.mul_sel)
      fca_pkg::MUL_PHASE: begin
        mul_a = {1'b0, wavenumber_turns};
        mul_b = {{3{pos_reg[31]}}, pos_reg};
      end
      fca_pkg::MUL_COS: begin
        mul_a = {q_reg[31], q_reg};
        mul_b = {cos_v[33], cos_v};
      end
      fca_pkg::MUL_SIN: begin
        mul_a = {q_reg[31], q_reg};
        mul_b = {sin_v[33], sin_v};
      end
      fca_pkg::MUL_LO: begin
        mul_a = {prefactor[31], prefactor};
        mul_b = {3'b000, sum_sel[31:0]};
      end
      fca_pkg::MUL_HI: begin
        mul_a = {prefactor[31], prefactor};
        mul_b = {{3{sum_sel[63]}}, sum_sel[63:32]};
      end
      default: begin
        mul_a = {1'b0, wavenumber_turns};
        mul_b = {{3{pos_reg[31]}}, pos_reg};
      end
    endcase
  end

  // Phase as a fraction of a turn; quadrants two and three fold by a half turn.
  always_comb begin
    phase = mul_p[39:8];
    p_rot = {phase[31] ^ (phase[31] ^ phase[30]), phase[30:0]};
  end

  always_comb begin
    dx    = y >>> cnt;
    dy    = x >>> cnt;
    angle = {2'b00, fca_pkg::angle_turn(cnt)};
  end

  always_comb begin
    prod_sh  = mul_p >>> 14;
    add_even = fca_pkg::sat_add(even_sum, prod_sh[63:0]);
    add_odd  = fca_pkg::sat_add(odd_sum, prod_sh[63:0]);
  end

  // Full 96-bit product from two partial products, floored by 16 bits.
  always_comb begin
    total   = {{28{pp_lo[67]}}, pp_lo} + {mul_p[63:0], 32'h0000_0000};
    shifted = total[95:16];
    sc_sat  = !((&shifted[79:63]) || (~|shifted[79:63]));
    if (sc_sat) begin
      sc_val = shifted[79] ? fca_pkg::SUM_MIN : fca_pkg::SUM_MAX;
    end else begin
      sc_val = shifted[63:0];
    end
  end

  assign status.rot_last = (cnt == fca_pkg::STEP_W'(STEPS_RUN - 1));
  assign status.last     = last_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      wavenumber_turns <= '0;
      prefactor        <= fca_pkg::PREFACTOR_RST;
    end else if (cfg_valid) begin
      case (fca_pkg::cfg_reg_t'(cfg_index))
        fca_pkg::REG_WAVENUMBER: wavenumber_turns <= cfg_data;
        fca_pkg::REG_PREFACTOR:  prefactor        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (cmd.hold_lo) begin
      pp_lo <= mul_p;
    end
    if (cmd.capture_in) begin
      q_reg    <= quantity;
      pos_reg  <= position;
      last_reg <= last;
    end
    if (cmd.load_cordic) begin
      x    <= fca_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= {{2{p_rot[31]}}, p_rot};
      flip <= phase[31] ^ phase[30];
      cnt  <= '0;
    end else if (cmd.rotate) begin
      cnt <= cnt + 1'b1;
      if (!z[33]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - angle;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + angle;
      end
    end
    if (cmd.write_scaled) begin
      if (cmd.scale_odd) begin
        coefficient_odd <= sc_val;
        saturated       <= overflow_seen | sc_sat;
      end else begin
        coefficient_even <= sc_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      even_sum      <= '0;
      odd_sum       <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.clear_acc) begin
      even_sum      <= '0;
      odd_sum       <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.acc_even) begin
        even_sum <= add_even[63:0];
        if (add_even[64]) begin
          overflow_seen <= 1'b1;
        end
      end
      if (cmd.acc_odd) begin
        odd_sum <= add_odd[63:0];
        if (add_odd[64]) begin
          overflow_seen <= 1'b1;
        end
      end
      if (cmd.write_scaled && sc_sat) begin
        overflow_seen <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/fourier_coefficient_accumulator.sv =====
// Single-bin Fourier coefficient accumulator.
// Input channel (in_valid/in_ready): one particle per request, its quantity and
// position in signed Q16.16 and a last flag that closes a set of particles.
// Output channel (out_valid/out_ready): one request per set, carrying the even
// and odd coefficients in signed Q32.32 and a sticky saturation flag.
// Configuration channel (cfg_valid/cfg_ready): index 0 writes the wavenumber
// in turns per unit length (unsigned Q8.24), index 1 the prefactor (Q16.16).
// cfg_ready is always high; writes are meant to happen while the block is idle.
// Each particle passes through the shared CORDIC rotator, which takes one step
// per cycle, and the single shared multiplier; no new particle is taken until
// the last one is accumulated. A closing particle holds the input longer: it
// waits for the output register to be free and then scales both sums in turn.
// A finished result waits in the output register while the next particle is
// accepted and accumulated. If the receiver stalls, a later closing particle
// holds in front of scaling until the pending result is taken.
// Reset clears the accumulators and the internal saturation flag, sets the
// wavenumber to zero and the prefactor to one, and drops out_valid.
module fourier_coefficient_accumulator #(
  parameter int unsigned CORDIC_STEPS = fca_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] quantity,
  input  logic signed [31:0] position,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] coefficient_even,
  output logic signed [63:0] coefficient_odd,
  output logic               saturated
);

  fca_pkg::cmd_t    cmd;
  fca_pkg::status_t status;

  // Configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  fca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fca_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .quantity         (quantity),
    .position         (position),
    .last             (last),
    .cmd              (cmd),
    .status           (status),
    .coefficient_even (coefficient_even),
    .coefficient_odd  (coefficient_odd),
    .saturated        (saturated)
  );

endmodule

// ===== rtl/fca_checker.sv =====
module fca_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [63:0] coefficient_even,
  input logic signed [63:0] coefficient_odd,
  input logic               saturated
);

  // A particle occupies the block, so no request is taken right after one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // A result appears only as scaling finishes, when the input side was busy.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coefficient_even)
      && $stable(coefficient_odd) && $stable(saturated))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind fourier_coefficient_accumulator fca_checker u_fca_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .coefficient_even (coefficient_even),
  .coefficient_odd  (coefficient_odd),
  .saturated        (saturated)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // The bench runs the block at its default rotator length, so the predictor
  // uses the same number of steps, capped at the length of the angle table.
  localparam int unsigned STEPS = fca_pkg::CORDIC_STEPS_DEF;
  localparam int unsigned ROT_STEPS = (STEPS > 30) ? 30 : STEPS;

  // The settle wait covers a particle that is still being accumulated when
  // the last result has already gone out.
  localparam int SETTLE_CYCLES = 2 * STEPS + 40;

  // Generous watchdog: far above the slowest legal run of this stimulus.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Length of the long receiver hold-off that makes the block back up.
  localparam int HOLD_CYCLES = 400;

  localparam int ITEMS_PER_PHASE = 138;
  localparam int MAX_PRINTED = 100;

  localparam logic signed [64:0] SUM_MAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_MIN65 = -65'sh0_8000_0000_0000_0000;
  localparam logic signed [95:0] SUM_MAX96 = 96'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [95:0] SUM_MIN96 = -96'sh8000_0000_0000_0000;

  // Arctangent of 2^-i, in units of 2^-32 turn, truncated.
  localparam logic [31:0] ATAN_TURNS [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // One emitted coefficient pair as the predictor expects it.
  typedef struct packed {
    logic signed [63:0] even;
    logic signed [63:0] odd;
    logic               sat;
  } coeff_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  fca_pkg::cfg_reg_t  cfg_index = fca_pkg::REG_WAVENUMBER;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] quantity = '0;
  logic signed [31:0] position = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] coefficient_even;
  logic signed [63:0] coefficient_odd;
  logic               saturated;

  fourier_coefficient_accumulator u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .quantity         (quantity),
    .position         (position),
    .last             (last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .coefficient_even (coefficient_even),
    .coefficient_odd  (coefficient_odd),
    .saturated        (saturated)
  );

  // The predictor's own copy of the registers and the running sums.
  logic [31:0]        model_wavenumber = '0;
  logic signed [31:0] model_prefactor = fca_pkg::PREFACTOR_RST;
  logic signed [63:0] even_acc = '0;
  logic signed [63:0] odd_acc = '0;
  bit                 sticky_sat = 1'b0;

  coeff_t expected_coeffs[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;        // when set, neither side idles
  bit  hold_request = 1'b0;  // asks the receiver for a long hold-off
  bit  holding = 1'b0;       // the receiver is inside that hold-off
  int  hold_left = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog. A hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Idle lengths: most are zero or short, a few are long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Fixed-length CORDIC on a phase given as an unsigned fraction of a turn.
  // Phases in the middle half of the circle are folded by half a turn and
  // the outputs negated, so the rotator only sees [-1/4, 1/4) turn.
  function automatic void rotate_phase(input logic [31:0] phase,
                                       output logic signed [63:0] cos_v,
                                       output logic signed [63:0] sin_v);
    logic [31:0] p;
    logic signed [63:0] x, y, z, dx, dy;
    bit flip;
    int i;
    p = phase;
    flip = (p[31:30] == 2'b01) || (p[31:30] == 2'b10);
    if (flip) p = p - 32'h8000_0000;
    z = $signed({{32{p[31]}}, p});
    x = 64'sh26DD3B6A;
    y = '0;
    for (i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - $signed({32'h0, ATAN_TURNS[i]});
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + $signed({32'h0, ATAN_TURNS[i]});
      end
    end
    cos_v = flip ? -x : x;
    sin_v = flip ? -y : y;
  endfunction

  // Accumulator add that clamps to the signed 64-bit range.
  function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     output bit hit);
    logic signed [64:0] s;
    s = a + b;
    hit = 1'b0;
    if (s > SUM_MAX65) begin
      hit = 1'b1;
      return fca_pkg::SUM_MAX;
    end
    if (s < SUM_MIN65) begin
      hit = 1'b1;
      return fca_pkg::SUM_MIN;
    end
    return s[63:0];
  endfunction

  // Exact prefactor times sum, floor-shifted by 16 and clamped to 64 bits.
  function automatic logic signed [63:0] scale_clamped(input logic signed [63:0] sum,
                                                       input logic signed [31:0] pf,
                                                       output bit hit);
    logic signed [95:0] a96, p96, prod, shifted;
    a96 = sum;
    p96 = pf;
    prod = a96 * p96;
    shifted = prod >>> 16;
    hit = 1'b0;
    if (shifted > SUM_MAX96) begin
      hit = 1'b1;
      return fca_pkg::SUM_MAX;
    end
    if (shifted < SUM_MIN96) begin
      hit = 1'b1;
      return fca_pkg::SUM_MIN;
    end
    return shifted[63:0];
  endfunction

  // Adds one accepted particle to the predicted sums and, on a closing
  // particle, queues the coefficient pair the block must emit.
  task automatic predict_particle(input logic signed [31:0] q,
                                  input logic signed [31:0] pos,
                                  input logic is_last);
    logic [63:0] turns;
    logic signed [63:0] cos_v, sin_v, q64, even_term, odd_term;
    bit hit;
    coeff_t res;
    turns = {32'h0, model_wavenumber} * {{32{pos[31]}}, pos};
    rotate_phase(turns[39:8], cos_v, sin_v);
    q64 = q;
    even_term = (q64 * cos_v) >>> 14;
    odd_term = (q64 * sin_v) >>> 14;
    even_acc = add_clamped(even_acc, even_term, hit);
    sticky_sat |= hit;
    odd_acc = add_clamped(odd_acc, odd_term, hit);
    sticky_sat |= hit;
    if (is_last) begin
      res.sat = sticky_sat;
      res.even = scale_clamped(even_acc, model_prefactor, hit);
      res.sat |= hit;
      res.odd = scale_clamped(odd_acc, model_prefactor, hit);
      res.sat |= hit;
      expected_coeffs.push_back(res);
      even_acc = '0;
      odd_acc = '0;
      sticky_sat = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_PRINTED)
      $display("tb: mismatch on %s: got %h, want %h", what, got, want);
    error_count++;
  endtask

  // Offers one particle and returns at the falling edge after it was taken.
  // Valid is left high so that a back-to-back request needs no extra edge;
  // a gap in the next call, or the drain, lowers it.
  task automatic send_particle(input logic signed [31:0] q,
                               input logic signed [31:0] pos,
                               input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    quantity <= q;
    position <= pos;
    last <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_particle(q, pos, is_last);
    @(negedge clk);
  endtask

  // Stops offering, waits for every expected result and then lets the block
  // finish any particle that produces no result.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_coeffs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes both registers while the block is idle.
  task automatic configure(input logic [31:0] wn, input logic [31:0] pf);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_index <= fca_pkg::REG_WAVENUMBER;
    cfg_data <= wn;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_wavenumber = wn;
    @(negedge clk);
    cfg_index <= fca_pkg::REG_PREFACTOR;
    cfg_data <= pf;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_prefactor = pf;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_quantity();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (r < 40) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (r < 30) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    return $urandom;
  endfunction

  // Receiver: random stalls, plus one long hold-off when the main sequence
  // asks for it. The hold-off is counted here, cycle by cycle.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        holding = 1'b1;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
        hold_request = 1'b0;
        holding = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
    end
  end

  // Every result taken by the receiver is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    coeff_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_coeffs.size() == 0) begin
        report_mismatch("unexpected result", coefficient_even, '0);
      end else begin
        want = expected_coeffs.pop_front();
        if (coefficient_even !== want.even)
          report_mismatch("coefficient_even", coefficient_even, want.even);
        if (coefficient_odd !== want.odd)
          report_mismatch("coefficient_odd", coefficient_odd, want.odd);
        if (saturated !== want.sat)
          report_mismatch("saturated", {63'h0, saturated}, {63'h0, want.sat});
      end
    end
  end

  // Reset values: a zero wavenumber puts every particle at phase zero, and
  // a closing first particle must come out on its own.
  task automatic test_reset_defaults();
    send_particle(32'h0001_0000, 32'h0000_0000, 1'b1);
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_particle(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
  endtask

  // One turn per unit length, so the positions below land on the quadrant
  // edges and just beside them, where the half-turn fold switches.
  task automatic test_quadrant_edges();
    logic [31:0] spots[7];
    int k;
    spots = '{32'h0000_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_C000,
              32'hFFFF_C000, 32'h0000_3FFF, 32'h0000_4001};
    configure(32'h0100_0000, 32'h0001_0000);
    for (k = 0; k < 7; k++)
      send_particle(32'h0001_0000, spots[k], 1'b1);
  endtask

  // Extreme registers: the largest prefactors push the final scaling into
  // saturation at both bounds, a zero prefactor wipes the sums out and a
  // negative one flips them.
  task automatic test_scaling_extremes();
    int k;
    configure(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    for (k = 0; k < 4; k++)
      send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF - k, k == 3);
    configure(32'h0000_0000, 32'h8000_0000);
    for (k = 0; k < 4; k++)
      send_particle(32'h7FFF_FFFF, 32'h0001_0000, k == 3);
    configure(32'h0000_0000, 32'h0000_0000);
    send_particle(32'h8000_0000, 32'h8000_0000, 1'b1);
    configure(32'hFFFF_FFFF, 32'hFFFF_0000);
    send_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
  endtask

  // The receiver holds off for a long stretch while closing particles keep
  // coming back to back, so the output register fills and input stalls.
  task automatic test_output_backpressure();
    int k;
    configure($urandom, 32'h0001_0000);
    hold_request = 1'b1;
    wait (holding);
    steady = 1'b1;
    for (k = 0; k < 24; k++)
      send_particle(pick_quantity(), pick_position(), 1'b1);
    steady = 1'b0;
  endtask

  // Random sets of particles under a sequence of register settings. Most
  // sets are short and closed properly; now and then a stray last bit
  // splits or merges sets.
  task automatic test_random_sets();
    logic [31:0] wn_list[8];
    logic [31:0] pf_list[8];
    int ph, sent, set_len, k;
    logic is_last;
    wn_list = '{$urandom, 32'hFFFF_FFFF, $urandom, $urandom,
                32'h0000_0000, $urandom, 32'h0000_0001, $urandom_range(0, 32'h0400_0000)};
    pf_list = '{32'h0001_0000, $urandom, 32'h8000_0000, 32'h7FFF_FFFF,
                $urandom, $urandom, $urandom, $urandom_range(0, 32'h0004_0000)};
    for (ph = 0; ph < 8; ph++) begin
      configure(wn_list[ph], pf_list[ph]);
      steady = (ph % 3 == 2);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 5);
        for (k = 0; k < set_len; k++) begin
          is_last = (k == set_len - 1);
          if ($urandom_range(0, 11) == 0) is_last = $urandom_range(0, 1);
          send_particle(pick_quantity(), pick_position(), is_last);
        end
        sent += set_len;
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_quadrant_edges();
    test_scaling_extremes();
    test_output_backpressure();
    test_random_sets();

    drain_block();
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fca_pkg.sv
rtl/fca_ctrl.sv
rtl/fca_datapath.sv
rtl/fourier_coefficient_accumulator.sv
rtl/fca_checker.sv
sim/tb.sv
